>>> rtl/dcfd_pkg.sv
package dcfd_pkg;

    localparam int unsigned PULSE_W    = 15;
    localparam int unsigned WORD_W     = 16;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned N_CHAN     = 4;
    localparam int unsigned N_PAYLOAD  = 8;
    localparam int unsigned PAYLOAD_IW = $clog2(N_PAYLOAD);
    localparam int unsigned ADDR_W     = 4;
    localparam int unsigned DATA_W     = 32;

    localparam logic [BYTE_W-1:0] START_BYTE = 8'h73;
    localparam logic [BYTE_W-1:0] END_BYTE   = 8'h65;

    localparam logic [PULSE_W-1:0] MIN_RESET     = 15'd1000;
    localparam logic [PULSE_W-1:0] MAX_RESET     = 15'd2000;
    localparam logic [PULSE_W-1:0] NEUTRAL_RESET = 15'd1500;

    // Register index, taken from paddr[3:2]
    typedef enum logic [1:0] {
        REG_MIN     = 2'd0,
        REG_MAX     = 2'd1,
        REG_NEUTRAL = 2'd2,
        REG_NONE    = 2'd3
    } reg_idx_t;

    typedef enum logic [3:0] {
        PH_HUNT    = 4'b0001,
        PH_PAYLOAD = 4'b0010,
        PH_STOP    = 4'b0100,
        PH_TAIL    = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [PULSE_W-1:0] min_pulse;
        logic [PULSE_W-1:0] max_pulse;
        logic [PULSE_W-1:0] neutral_pulse;
    } cfg_t;

    typedef struct packed {
        logic [N_CHAN-1:0][WORD_W-1:0] words;
        logic                          stop_set;
    } frame_t;

endpackage

>>> rtl/dcfd_cfg_regs.sv
module dcfd_cfg_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [dcfd_pkg::ADDR_W-1:0] paddr,
    input  logic [dcfd_pkg::DATA_W-1:0] pwdata,
    output logic [dcfd_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output dcfd_pkg::cfg_t             cfg
);
    import dcfd_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_MIN:     cfg_next.min_pulse     = pwdata[PULSE_W-1:0];
                REG_MAX:     cfg_next.max_pulse     = pwdata[PULSE_W-1:0];
                REG_NEUTRAL: cfg_next.neutral_pulse = pwdata[PULSE_W-1:0];
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_MIN:     prdata = {{(DATA_W-PULSE_W){1'b0}}, cfg_reg.min_pulse};
            REG_MAX:     prdata = {{(DATA_W-PULSE_W){1'b0}}, cfg_reg.max_pulse};
            REG_NEUTRAL: prdata = {{(DATA_W-PULSE_W){1'b0}}, cfg_reg.neutral_pulse};
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_pulse     <= MIN_RESET;
            cfg_reg.max_pulse     <= MAX_RESET;
            cfg_reg.neutral_pulse <= NEUTRAL_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> rtl/dcfd_frame_rx.sv
module dcfd_frame_rx (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  logic [dcfd_pkg::BYTE_W-1:0] rx_byte,
    output logic                        in_tail,
    output logic                        frame_done,
    output dcfd_pkg::frame_t            frame
);
    import dcfd_pkg::*;

    phase_t                phase_reg;
    phase_t                phase_next;
    logic [PAYLOAD_IW-1:0] cnt_reg;
    logic [PAYLOAD_IW-1:0] cnt_next;
    logic [BYTE_W-1:0]     payload_reg [N_PAYLOAD];
    logic [BYTE_W-1:0]     stop_reg;
    logic                  pay_we;
    logic                  stop_we;

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        pay_we     = 1'b0;
        stop_we    = 1'b0;
        frame_done = 1'b0;
        if (accept)
        begin
            unique case (phase_reg)
                PH_PAYLOAD:
                begin
                    pay_we   = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == PAYLOAD_IW'(N_PAYLOAD - 1))
                        phase_next = PH_STOP;
                end
                PH_STOP:
                begin
                    stop_we    = 1'b1;
                    phase_next = PH_TAIL;
                end
                PH_TAIL:
                begin
                    if (rx_byte == END_BYTE)
                    begin
                        frame_done = 1'b1;
                        phase_next = PH_HUNT;
                    end
                end
                default:
                begin
                    // hunt, and any stray code behaves as hunt
                    cnt_next   = '0;
                    phase_next = (rx_byte == START_BYTE) ? PH_PAYLOAD : PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            cnt_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pay_we)
            payload_reg[cnt_reg] <= rx_byte;
        if (stop_we)
            stop_reg <= rx_byte;
    end

    always_comb
    begin
        for (int k = 0; k < N_CHAN; k++)
            frame.words[k] = {payload_reg[2*k+1], payload_reg[2*k]};
        frame.stop_set = (stop_reg != '0);
    end

    assign in_tail = (phase_reg == PH_TAIL);

endmodule

>>> rtl/dcfd_pulse_out.sv
module dcfd_pulse_out (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         load,
    input  dcfd_pkg::frame_t             frame,
    input  dcfd_pkg::cfg_t               cfg,
    input  logic                         cmd_stall,
    output logic                         cmd_valid,
    output logic [dcfd_pkg::PULSE_W-1:0] front_left_pulse,
    output logic [dcfd_pkg::PULSE_W-1:0] front_right_pulse,
    output logic [dcfd_pkg::PULSE_W-1:0] back_left_pulse,
    output logic [dcfd_pkg::PULSE_W-1:0] back_right_pulse,
    output logic                         stop_forced
);
    import dcfd_pkg::*;

    logic [N_CHAN-1:0][PULSE_W-1:0] pulse_next;
    logic [N_CHAN-1:0][PULSE_W-1:0] pulse_reg;
    logic                           stop_reg;
    logic                           valid_reg;
    logic                           valid_next;
    logic signed [WORD_W-1:0]       lo;
    logic signed [WORD_W-1:0]       hi;

    assign lo = $signed({1'b0, cfg.min_pulse});
    assign hi = $signed({1'b0, cfg.max_pulse});

    // Range check each channel; the stop flag overrides everything.
    always_comb
    begin
        for (int k = 0; k < N_CHAN; k++)
        begin
            if (frame.stop_set
                || ($signed(frame.words[k]) < lo)
                || ($signed(frame.words[k]) > hi))
                pulse_next[k] = cfg.neutral_pulse;
            else
                pulse_next[k] = frame.words[k][PULSE_W-1:0];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (valid_reg && !cmd_stall)
            valid_next = 1'b0;
        if (load)
            valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pulse_reg <= pulse_next;
            stop_reg  <= frame.stop_set;
        end
    end

    assign cmd_valid         = valid_reg;
    assign front_left_pulse  = pulse_reg[0];
    assign front_right_pulse = pulse_reg[1];
    assign back_left_pulse   = pulse_reg[2];
    assign back_right_pulse  = pulse_reg[3];
    assign stop_forced       = stop_reg;

endmodule

>>> rtl/drive_command_frame_decoder_unit.sv
// The command word is loaded into its register at the same clock edge that takes the frame's end byte.
// Throughput: one byte per cycle; bytes outside the tail phase are taken even while a
//   command word waits, and only a byte arriving in the tail phase waits on a held command.
// Reset (rst_n low, asynchronous): decoder hunts for the start byte, no command pending,
//   limits return to 1000 / 2000 with neutral 1500.
module drive_command_frame_decoder_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    // byte channel
    input  logic                         rx_valid,
    output logic                         rx_stall,
    input  logic [dcfd_pkg::BYTE_W-1:0]  rx_byte,
    // command channel
    output logic                         cmd_valid,
    input  logic                         cmd_stall,
    output logic [dcfd_pkg::PULSE_W-1:0] front_left_pulse,
    output logic [dcfd_pkg::PULSE_W-1:0] front_right_pulse,
    output logic [dcfd_pkg::PULSE_W-1:0] back_left_pulse,
    output logic [dcfd_pkg::PULSE_W-1:0] back_right_pulse,
    output logic                         stop_forced,
    // register port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [dcfd_pkg::ADDR_W-1:0]  paddr,
    input  logic [dcfd_pkg::DATA_W-1:0]  pwdata,
    output logic [dcfd_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);
    import dcfd_pkg::*;

    cfg_t   cfg;
    frame_t frame;
    logic   in_tail;
    logic   frame_done;
    logic   accept;

    // Hold bytes only in the tail phase while a finished command is still
    // waiting downstream: any tail byte may be the end byte that needs the
    // output register. Every other phase keeps draining the serial stream.
    assign rx_stall = in_tail && cmd_valid && cmd_stall;
    assign accept   = rx_valid && !rx_stall;

    // Limit, maximum and neutral width registers
    dcfd_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Frame phase machine: hunt start, capture payload and stop flag, hunt end
    dcfd_frame_rx u_rx (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .rx_byte    (rx_byte),
        .in_tail    (in_tail),
        .frame_done (frame_done),
        .frame      (frame)
    );

    // Range check of the four widths straight into the command register
    dcfd_pulse_out u_out (
        .clk               (clk),
        .rst_n             (rst_n),
        .load              (frame_done),
        .frame             (frame),
        .cfg               (cfg),
        .cmd_stall         (cmd_stall),
        .cmd_valid         (cmd_valid),
        .front_left_pulse  (front_left_pulse),
        .front_right_pulse (front_right_pulse),
        .back_left_pulse   (back_left_pulse),
        .back_right_pulse  (back_right_pulse),
        .stop_forced       (stop_forced)
    );

`ifndef SYNTHESIS
    // Input is held back only on account of a pending command
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        rx_stall |-> cmd_valid)
        else $error("byte stalled with no command pending");

    // A completed frame always shows up as a command word
    a_frame_lands: assert property (@(posedge clk) disable iff (!rst_n)
        frame_done |=> cmd_valid)
        else $error("completed frame did not reach the command register");

    // A forced stop drives every channel to the same width
    a_stop_uniform: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && stop_forced) |->
            (front_left_pulse == front_right_pulse
             && front_left_pulse == back_left_pulse
             && front_left_pulse == back_right_pulse))
        else $error("stop command with unequal channel widths");
`endif

endmodule

>>> dv/tb.sv
module tb;

    import dcfd_pkg::reg_idx_t;
    import dcfd_pkg::REG_MIN;
    import dcfd_pkg::REG_MAX;
    import dcfd_pkg::REG_NEUTRAL;

    localparam int unsigned PW = dcfd_pkg::PULSE_W;
    localparam int unsigned BW = dcfd_pkg::BYTE_W;

    // Frame phase codes of the decoder model: hunt, payload 1..8, stop flag, tail
    localparam int unsigned FRM_HUNT = 0;
    localparam int unsigned FRM_LAST_PAYLOAD = dcfd_pkg::N_PAYLOAD;
    localparam int unsigned FRM_FLAG = FRM_LAST_PAYLOAD + 1;
    localparam int unsigned FRM_TAIL = FRM_LAST_PAYLOAD + 2;

    localparam int unsigned IDLE_PCT = 38;

    // One command word: channel 0 front left, 1 front right, 2 back left, 3 back right
    typedef struct packed {
        logic [dcfd_pkg::N_CHAN-1:0][PW-1:0] pulse;
        logic                                stop;
    } command_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                         rx_valid = 1'b0;
    logic                         rx_stall;
    logic [BW-1:0]                rx_byte = '0;
    logic                         cmd_valid;
    logic                         cmd_stall = 1'b0;
    logic [PW-1:0]                front_left_pulse;
    logic [PW-1:0]                front_right_pulse;
    logic [PW-1:0]                back_left_pulse;
    logic [PW-1:0]                back_right_pulse;
    logic                         stop_forced;
    logic                         psel = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite = 1'b0;
    logic [dcfd_pkg::ADDR_W-1:0]  paddr = '0;
    logic [dcfd_pkg::DATA_W-1:0]  pwdata = '0;
    logic [dcfd_pkg::DATA_W-1:0]  prdata;
    logic                         pready;

    drive_command_frame_decoder_unit i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .rx_valid          (rx_valid),
        .rx_stall          (rx_stall),
        .rx_byte           (rx_byte),
        .cmd_valid         (cmd_valid),
        .cmd_stall         (cmd_stall),
        .front_left_pulse  (front_left_pulse),
        .front_right_pulse (front_right_pulse),
        .back_left_pulse   (back_left_pulse),
        .back_right_pulse  (back_right_pulse),
        .stop_forced       (stop_forced),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Frame decoder model state and its copy of the limit registers
    int unsigned   frame_phase = FRM_HUNT;
    logic [BW-1:0] frame_bytes [dcfd_pkg::N_PAYLOAD];
    logic [BW-1:0] flag_byte;
    logic [PW-1:0] lim_min = dcfd_pkg::MIN_RESET;
    logic [PW-1:0] lim_max = dcfd_pkg::MAX_RESET;
    logic [PW-1:0] lim_neutral = dcfd_pkg::NEUTRAL_RESET;

    command_t due_commands [$];
    int       error_count = 0;
    int       bytes_taken = 0;
    // Set to switch off all idling on both channels
    bit       steady_flow = 1'b0;

    // Advance the model by one accepted byte; queue the command word an end byte yields.
    task automatic decode_rx_byte(input logic [BW-1:0] b);
        command_t          cmd;
        logic signed [15:0] width;
        int                k;
        if (frame_phase >= 1 && frame_phase <= FRM_LAST_PAYLOAD)
        begin
            // marker values here are plain data
            frame_bytes[frame_phase-1] = b;
            frame_phase++;
        end
        else if (frame_phase == FRM_FLAG)
        begin
            flag_byte = b;
            frame_phase = FRM_TAIL;
        end
        else if (frame_phase == FRM_TAIL)
        begin
            if (b == dcfd_pkg::END_BYTE)
            begin
                frame_phase = FRM_HUNT;
                cmd.stop = (flag_byte != '0);
                for (k = 0; k < dcfd_pkg::N_CHAN; k++)
                begin
                    width = {frame_bytes[2*k+1], frame_bytes[2*k]};
                    // stop overrides all range checks; negative widths fall below any min
                    if (cmd.stop || int'(width) < int'(lim_min) || int'(width) > int'(lim_max))
                        cmd.pulse[k] = lim_neutral;
                    else
                        cmd.pulse[k] = width[PW-1:0];
                end
                due_commands.push_back(cmd);
            end
        end
        else
        begin
            frame_phase = (b == dcfd_pkg::START_BYTE) ? 1 : FRM_HUNT;
        end
    endtask

    // Command channel backpressure: stall at random unless the flow is steady
    always @(posedge clk)
        cmd_stall <= !steady_flow && ($urandom_range(0, 99) < IDLE_PCT);

    // Compare every accepted command word with the oldest one due
    always @(posedge clk)
    begin : check_commands
        command_t want;
        logic [dcfd_pkg::N_CHAN-1:0][PW-1:0] got;
        string chan_name [dcfd_pkg::N_CHAN];
        int k;
        chan_name = '{"front_left_pulse", "front_right_pulse",
                      "back_left_pulse", "back_right_pulse"};
        if (rst_n && cmd_valid && !cmd_stall)
        begin
            if (due_commands.size() == 0)
            begin
                $error("command word with none due");
                error_count++;
            end
            else
            begin
                want = due_commands.pop_front();
                got = {back_right_pulse, back_left_pulse, front_right_pulse, front_left_pulse};
                for (k = 0; k < dcfd_pkg::N_CHAN; k++)
                begin
                    if (got[k] !== want.pulse[k])
                    begin
                        $error("%s: expected %0d, got %0d", chan_name[k], want.pulse[k], got[k]);
                        error_count++;
                    end
                end
                if (stop_forced !== want.stop)
                begin
                    $error("stop_forced: expected %0b, got %0b", want.stop, stop_forced);
                    error_count++;
                end
            end
        end
    end

    // Offer one byte, with a random gap in front, and hold it until taken.
    // Called and returns at a rising edge; rx_valid stays high for a following byte.
    task automatic send_byte(input logic [BW-1:0] b);
        int gap;
        gap = (!steady_flow && $urandom_range(0, 99) < IDLE_PCT) ? $urandom_range(1, 2) : 0;
        if (gap != 0)
        begin
            rx_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte <= b;
        do
            @(posedge clk);
        while (rx_stall);
        decode_rx_byte(b);
        bytes_taken++;
    endtask

    // Drop valid and hold until every command word due has come out
    task automatic wait_for_commands();
        rx_valid <= 1'b0;
        while (due_commands.size() != 0)
            @(posedge clk);
        // leave margin for a byte still in flight
        repeat (4) @(posedge clk);
    endtask

    // Register write: setup cycle, access cycle, then release the bus
    task automatic write_reg(input reg_idx_t idx, input logic [PW-1:0] value);
        logic [dcfd_pkg::DATA_W-1:0] data;
        data = $urandom;
        data[PW-1:0] = value;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= dcfd_pkg::ADDR_W'({idx, 2'b00});
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_MIN: lim_min = value;
            REG_MAX: lim_max = value;
            REG_NEUTRAL: lim_neutral = value;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_limits(input logic [PW-1:0] lo, input logic [PW-1:0] hi,
                              input logic [PW-1:0] neutral);
        wait_for_commands();
        write_reg(REG_MIN, lo);
        write_reg(REG_MAX, hi);
        write_reg(REG_NEUTRAL, neutral);
    endtask

    function automatic logic [BW-1:0] byte_other_than(input logic [BW-1:0] avoid);
        logic [BW-1:0] b;
        do
            b = BW'($urandom);
        while (b == avoid);
        return b;
    endfunction

    // Pick a 16-bit width, weighted toward the range edges and the sign extremes
    function automatic logic [15:0] pick_width();
        case ($urandom_range(0, 9))
            0: return 16'(lim_min) - 16'd1;
            1: return 16'(lim_min);
            2: return 16'(lim_max);
            3: return 16'(lim_max) + 16'd1;
            4: return (lim_min <= lim_max) ? 16'($urandom_range(lim_min, lim_max)) : 16'($urandom);
            5: return 16'h8000;
            6: return 16'h7fff;
            7: return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    // Start byte, four little-endian widths, stop flag, tail junk, end byte
    task automatic send_frame(input logic [15:0] w0, input logic [15:0] w1,
                              input logic [15:0] w2, input logic [15:0] w3,
                              input logic [BW-1:0] flag, input int junk);
        logic [3:0][15:0] widths;
        int k;
        widths = {w3, w2, w1, w0};
        send_byte(dcfd_pkg::START_BYTE);
        for (k = 0; k < dcfd_pkg::N_CHAN; k++)
        begin
            send_byte(widths[k][7:0]);
            send_byte(widths[k][15:8]);
        end
        send_byte(flag);
        // a start byte in the tail must be ignored
        repeat (junk)
            send_byte(($urandom_range(0, 3) == 0) ? dcfd_pkg::START_BYTE
                                                  : byte_other_than(dcfd_pkg::END_BYTE));
        send_byte(dcfd_pkg::END_BYTE);
    endtask

    task automatic send_random_frame();
        logic [BW-1:0] flag;
        repeat ($urandom_range(0, 2))
            send_byte(byte_other_than(dcfd_pkg::START_BYTE));
        case ($urandom_range(0, 7))
            0: flag = ($urandom_range(0, 1) == 0) ? dcfd_pkg::START_BYTE : dcfd_pkg::END_BYTE;
            1: flag = byte_other_than(8'h00);
            default: flag = 8'h00;
        endcase
        send_frame(pick_width(), pick_width(), pick_width(), pick_width(),
                   flag, $urandom_range(0, 2));
    endtask

    // Unstructured bytes: cut frames, stray markers, anything at all
    task automatic send_noise();
        repeat ($urandom_range(1, 12))
        begin
            case ($urandom_range(0, 7))
                0: send_byte(dcfd_pkg::START_BYTE);
                1: send_byte(dcfd_pkg::END_BYTE);
                default: send_byte(BW'($urandom));
            endcase
        end
    endtask

    // Mostly well-formed frames with random content, the rest noise;
    // now and then hold off until every command word has drained
    task automatic run_random_traffic(input int n_bytes);
        int stop_at;
        stop_at = bytes_taken + n_bytes;
        while (bytes_taken < stop_at)
        begin
            if ($urandom_range(0, 39) == 0)
                wait_for_commands();
            if ($urandom_range(0, 3) != 0)
                send_random_frame();
            else
                send_noise();
        end
    endtask

    // Reset limits: sign extremes and both range edges, then markers carried as data
    task automatic test_directed_frames();
        send_byte(dcfd_pkg::END_BYTE);
        send_frame(16'h8000, 16'd1000, 16'd2000, 16'h7fff, 8'h00, 1);
        send_frame(16'h6573, 16'h7365, 16'd999, 16'd2001, dcfd_pkg::END_BYTE, 0);
        wait_for_commands();
    endtask

    // Walk the limit registers through their extremes, including min above max
    task automatic test_limit_settings();
        int i;
        for (i = 0; i < 6; i++)
        begin
            case (i)
                0: set_limits(15'd0, 15'h7fff, 15'd0);
                1: set_limits(15'h7fff, 15'd0, 15'h7fff);
                2: set_limits(15'd1234, 15'd1234, 15'd21845);
                3: set_limits(15'd0, 15'd0, 15'd10922);
                default: set_limits(PW'($urandom), PW'($urandom), PW'($urandom));
            endcase
            run_random_traffic(170);
        end
    endtask

    task automatic test_random_traffic();
        logic [PW-1:0] lo;
        lo = PW'($urandom_range(0, 16000));
        set_limits(lo, lo + 15'($urandom_range(0, 16000)), PW'($urandom));
        run_random_traffic(460);
    endtask

    // Back to reset limits, and a long stretch with no idling on either side
    task automatic test_no_idle_stretch();
        set_limits(dcfd_pkg::MIN_RESET, dcfd_pkg::MAX_RESET, dcfd_pkg::NEUTRAL_RESET);
        steady_flow = 1'b1;
        run_random_traffic(350);
        steady_flow = 1'b0;
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_frames();
        test_limit_settings();
        test_random_traffic();
        test_no_idle_stretch();
        wait_for_commands();
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial
    begin
        #3000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
